// File: rtl/core/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies; imported by every module of the block.
package fbpa_pkg;

	// Widths fixed by the request and result fields
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned CNT_W    = 7;
	localparam int unsigned POOL_MAX = 64;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOT_HELD = 2'd3
	} status_t;

	// Shift control broadcast along the free-list chain
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage

// File: rtl/core/fbpa_cell.sv
// One slot of the free-list chain: holds one freed index.
// Depends on fbpa_pkg for the index and control types.
module fbpa_cell
	import fbpa_pkg::*;
(
	input  logic     clk,
	input  stk_ctl_t ctl,
	input  idx_t     from_above,
	input  idx_t     from_below,
	output idx_t     value
);

	idx_t value_q;

	// Shift down on push, up on pop, otherwise hold
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= from_above;
		end else if (ctl.pop) begin
			value_q <= from_below;
		end
	end

	assign value = value_q;

endmodule

// File: rtl/core/fbpa_stack.sv
// LIFO of freed indexes built as a row of shifting cells; top sits in cell 0.
// Depends on fbpa_pkg and fbpa_cell.
module fbpa_stack
	import fbpa_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic     clk,
	input  stk_ctl_t ctl,
	input  idx_t     push_data,
	output idx_t     top
);

	idx_t cell_val [DEPTH];

	// Wire each cell to its neighbours; the ends take the new index and zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		idx_t above;
		idx_t below;

		if (i == 0) begin : g_first
			assign above = push_data;
		end else begin : g_mid_a
			assign above = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid_b
			assign below = cell_val[i+1];
		end

		fbpa_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.value      (cell_val[i])
		);
	end

	assign top = cell_val[0];

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: request decode, counters,
// allocated map and result register. Depends on fbpa_pkg and fbpa_stack.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------
//  request  | in_valid / in_ready  | op, entry_index
//  result   | out_valid / out_ready| granted_index, status, in_use
//  config   | cfg_we               | cfg_wdata (pool size)
//
// Each request is decided in the cycle it is accepted and its result is
// registered, so one request per cycle is sustained while out_ready is high.
// The freed list shifts one slot along the cell chain on each push or pop.
// A new request is taken whenever the result register is empty or being read.
// Reset (and any pool size write) empties the freed list and clears the map
// at once; there is no start-up pass.
module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [IDX_W-1:0]     entry_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [IDX_W-1:0]     granted_index,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     in_use,
	input  logic                 cfg_we,
	input  logic [CNT_W-1:0]     cfg_wdata
);

	localparam int unsigned DEPTH = (MAX_ENTRIES < POOL_MAX) ? MAX_ENTRIES : POOL_MAX;
	localparam int unsigned MAP_W = $clog2(DEPTH);

	cnt_t             pool_entries_q;
	cnt_t             fresh_q;
	cnt_t             in_use_q;
	logic [DEPTH-1:0] alloc_map_q;

	logic             out_valid_q;
	idx_t             granted_q;
	status_t          status_q;
	cnt_t             in_use_out_q;

	logic             accept;
	cnt_t             pool_n;
	logic             list_empty;
	idx_t             top;
	stk_ctl_t         ctl;
	idx_t             granted_d;
	status_t          status_d;
	cnt_t             fresh_d;
	cnt_t             in_use_d;
	logic             map_set;
	logic             map_clr;
	logic [MAP_W-1:0] map_idx;
	logic [MAP_W-1:0] req_idx;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Clamp the pool size to 1..64 and to the storage depth
	always_comb begin
		if (pool_entries_q == '0) begin
			pool_n = cnt_t'(1);
		end else if (pool_entries_q > cnt_t'(DEPTH)) begin
			pool_n = cnt_t'(DEPTH);
		end else begin
			pool_n = pool_entries_q;
		end
	end

	// Freed-list length is fresh minus in use
	assign list_empty = (fresh_q == in_use_q);
	assign req_idx    = entry_index[MAP_W-1:0];

	// Decide the request and the state updates
	always_comb begin
		ctl       = '0;
		granted_d = '0;
		status_d  = ST_OK;
		fresh_d   = fresh_q;
		in_use_d  = in_use_q;
		map_set   = 1'b0;
		map_clr   = 1'b0;
		map_idx   = req_idx;
		unique case (op_t'(op))
			OP_ALLOC: begin
				priority if (!list_empty) begin
					granted_d = top;
					ctl.pop   = accept;
					map_set   = 1'b1;
					map_idx   = top[MAP_W-1:0];
					in_use_d  = in_use_q + cnt_t'(1);
				end else if (fresh_q < pool_n) begin
					granted_d = fresh_q[IDX_W-1:0];
					map_set   = 1'b1;
					map_idx   = fresh_q[MAP_W-1:0];
					fresh_d   = fresh_q + cnt_t'(1);
					in_use_d  = in_use_q + cnt_t'(1);
				end else begin
					status_d = ST_EMPTY;
				end
			end
			OP_FREE: begin
				priority if (cnt_t'(entry_index) >= pool_n) begin
					status_d = ST_RANGE;
				end else if (!alloc_map_q[req_idx]) begin
					status_d = ST_NOT_HELD;
				end else begin
					ctl.push = accept;
					map_clr  = 1'b1;
					in_use_d = in_use_q - cnt_t'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Pool state: size register, counters, allocated map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_entries_q <= cnt_t'(POOL_MAX);
			fresh_q        <= '0;
			in_use_q       <= '0;
			alloc_map_q    <= '0;
		end else if (cfg_we) begin
			pool_entries_q <= cfg_wdata;
			fresh_q        <= '0;
			in_use_q       <= '0;
			alloc_map_q    <= '0;
		end else if (accept) begin
			fresh_q  <= fresh_d;
			in_use_q <= in_use_d;
			if (map_set) begin
				alloc_map_q[map_idx] <= 1'b1;
			end else if (map_clr) begin
				alloc_map_q[map_idx] <= 1'b0;
			end
		end
	end

	fbpa_stack #(
		.DEPTH (DEPTH)
	) u_stack (
		.clk       (clk),
		.ctl       (ctl),
		.push_data (entry_index),
		.top       (top)
	);

	// Result register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_q    <= granted_d;
			status_q     <= status_d;
			in_use_out_q <= in_use_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted_index = granted_q;
	assign status        = status_q;
	assign in_use        = in_use_out_q;

endmodule

// File: tb/fixed_block_pool_allocator_checker.sv
// Result checker for the fixed block pool allocator: watches the request, result
// and pool size ports, predicts each result and compares it field by field.
// Depends on fbpa_pkg; reports its mismatch count and open expectations to the bench top.
module fixed_block_pool_allocator_checker
	import fbpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             op,
	input  logic [IDX_W-1:0] entry_index,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [IDX_W-1:0] granted_index,
	input  logic [1:0]       status,
	input  logic [CNT_W-1:0] in_use,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               pending
);

	typedef struct {
		idx_t    granted;
		status_t st;
		cnt_t    count;
	} pool_result_t;

	// Shadow allocator state
	cnt_t                size_reg;
	idx_t                links [POOL_MAX];
	logic [CNT_W-1:0]    head;
	cnt_t                fresh;
	cnt_t                taken;
	logic [POOL_MAX-1:0] held_map;

	pool_result_t expected_results[$];

	// Empty the freed list and forget every grant
	function automatic void clear_pool();
		head     = cnt_t'(POOL_MAX);
		fresh    = '0;
		taken    = '0;
		held_map = '0;
	endfunction

	// Work out the result of one request and advance the shadow state
	function automatic pool_result_t grant_or_release(op_t kind, idx_t idx);
		pool_result_t r;
		int unsigned  n;
		int unsigned  listed;
		idx_t         top;
		r = '{granted: '0, st: ST_OK, count: '0};
		n = (size_reg == 0) ? 1 : ((size_reg > POOL_MAX) ? POOL_MAX : size_reg);
		if (kind == OP_ALLOC) begin
			if (head < POOL_MAX && head < n) begin
				// pop the most recently freed entry
				top    = head[IDX_W-1:0];
				listed = fresh - taken;
				r.granted = top;
				head = (listed > 1) ? {1'b0, links[top]} : cnt_t'(POOL_MAX);
				held_map[top] = 1'b1;
				taken++;
			end else if (fresh < n) begin
				// hand out the next never-used index
				r.granted = fresh[IDX_W-1:0];
				held_map[fresh[IDX_W-1:0]] = 1'b1;
				fresh++;
				taken++;
			end else begin
				r.st = ST_EMPTY;
			end
		end else begin
			if (idx >= n) begin
				r.st = ST_RANGE;
			end else if (!held_map[idx]) begin
				r.st = ST_NOT_HELD;
			end else begin
				// push the entry back on the freed list
				if (head < POOL_MAX)
					links[idx] = head[IDX_W-1:0];
				head = {1'b0, idx};
				held_map[idx] = 1'b0;
				taken--;
			end
		end
		r.count = taken;
		return r;
	endfunction

	// Compare results first, then log the request accepted on the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		pool_result_t want;
		if (!arst_n) begin
			size_reg = cnt_t'(POOL_MAX);
			clear_pool();
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: granted_index %0d status %0d in_use %0d",
						granted_index, status, in_use);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (granted_index !== want.granted) begin
						$error("granted_index expected %0d got %0d", want.granted, granted_index);
						mismatches++;
					end
					if (status !== want.st) begin
						$error("status expected %0d got %0d", want.st, status);
						mismatches++;
					end
					if (in_use !== want.count) begin
						$error("in_use expected %0d got %0d", want.count, in_use);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(grant_or_release(op_t'(op), entry_index));
			if (cfg_we) begin
				size_reg = cfg_wdata;
				clear_pool();
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: tb/fixed_block_pool_allocator_tb.sv
// Bench top for the fixed block pool allocator: clock, reset, pool size writes
// and request stimulus. Depends on fbpa_pkg, the allocator and its result checker.
module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic in_valid    = 1'b0;
	logic in_ready;
	logic op          = OP_ALLOC;
	idx_t entry_index = '0;
	logic out_valid;
	logic out_ready   = 1'b0;
	idx_t granted_index;
	logic [1:0] status;
	cnt_t in_use;
	logic cfg_we      = 1'b0;
	cnt_t cfg_wdata   = '0;

	int   mismatches;
	int   pending;
	bit   send_gaps    = 1'b1;
	bit   drain_stalls = 1'b1;
	cnt_t pool_size    = cnt_t'(POOL_MAX);
	op_t  sent_ops[$];
	idx_t held[$];

	always #4 clk = ~clk;

	fixed_block_pool_allocator #(
		.MAX_ENTRIES(POOL_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted_index(granted_index),
		.status(status),
		.in_use(in_use),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	fixed_block_pool_allocator_checker pool_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted_index(granted_index),
		.status(status),
		.in_use(in_use),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.pending(pending)
	);

	// Stall the result side at random unless a steady stretch is running
	always @(negedge clk)
		out_ready <= drain_stalls ? ($urandom_range(0, 99) >= 32) : 1'b1;

	// Track granted entries so that most frees name an entry that is held
	always @(posedge clk) begin
		if (out_valid && out_ready && sent_ops.size() > 0) begin
			if (sent_ops.pop_front() == OP_ALLOC && status == ST_OK)
				held.push_back(granted_index);
		end
		if (in_valid && in_ready)
			sent_ops.push_back(op_t'(op));
	end

	// Offer one request and hold it until accepted; returns at a falling edge
	task automatic send_request(input op_t kind, input idx_t idx);
		while (send_gaps && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		op          <= kind;
		entry_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic grab();
		send_request(OP_ALLOC, idx_t'($urandom_range(0, POOL_MAX - 1)));
	endtask

	// Hold off new requests until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Change the pool size with the allocator idle
	task automatic write_pool_size(input cnt_t value);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		held.delete();
		pool_size = value;
	endtask

	initial begin
		cnt_t sizes [8];
		int   alloc_pct [8];
		int   lim;
		int   roll;
		int   pick;
		idx_t idx;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset size: fresh grants, reuse in LIFO order, double free
		grab();
		grab();
		grab();
		send_request(OP_FREE, 6'd1);
		send_request(OP_FREE, 6'd1);
		send_request(OP_FREE, 6'd63);
		grab();
		send_request(OP_FREE, 6'd0);
		send_request(OP_FREE, 6'd2);
		grab();
		grab();
		grab();

		// Size zero acts as a single entry: exhaustion and range refusal
		write_pool_size(7'd0);
		grab();
		grab();
		send_request(OP_FREE, 6'd1);
		send_request(OP_FREE, 6'd63);
		send_request(OP_FREE, 6'd0);
		send_request(OP_FREE, 6'd0);
		grab();

		// Oversized write is limited to the full pool and clears it
		write_pool_size(7'd127);
		send_request(OP_FREE, 6'd0);
		grab();

		// Two entries: fill, overflow, free both, reuse
		write_pool_size(7'd2);
		grab();
		grab();
		grab();
		send_request(OP_FREE, 6'd0);
		send_request(OP_FREE, 6'd1);
		grab();
		grab();

		sizes     = '{7'd1, 7'd2, 7'd64, 7'd127, 7'd7, 7'd65, 7'd3, 7'd64};
		sizes[6]  = cnt_t'($urandom_range(3, 127));
		alloc_pct = '{50, 60, 85, 85, 55, 70, 60, 75};

		// Random phases, one pool size each; phase 3 runs with no random gaps or stalls
		for (int p = 0; p < 8; p++) begin
			write_pool_size(sizes[p]);
			send_gaps    = (p != 3);
			drain_stalls = (p != 3);
			lim = (pool_size == 0) ? 1 : ((pool_size > POOL_MAX) ? POOL_MAX : pool_size);
			for (int k = 0; k < 100; k++) begin
				if (k == 50 && p % 3 == 0)
					drain();
				if ($urandom_range(0, 99) < alloc_pct[p]) begin
					grab();
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 65 && held.size() > 0) begin
						pick = $urandom_range(0, held.size() - 1);
						idx  = held[pick];
						held.delete(pick);
					end else if (roll < 90) begin
						idx = idx_t'($urandom_range(0, lim - 1));
					end else begin
						idx = idx_t'($urandom_range(0, POOL_MAX - 1));
					end
					send_request(OP_FREE, idx);
				end
			end
		end

		send_gaps    = 1'b1;
		drain_stalls = 1'b1;
		drain();
		repeat (4) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("fixed_block_pool_allocator: match");
		else
			$display("fixed_block_pool_allocator: mismatch");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#2000000;
		$display("fixed_block_pool_allocator: mismatch");
		$finish;
	end

endmodule
